// ===== src/cmga_pkg.sv =====
package cmga_pkg;

    // grid geometry
    localparam int GRID_ROWS  = 9;
    localparam int GRID_COLS  = 9;
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    // field widths
    localparam int COORD_W  = 24;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 7;
    localparam int HIT_W    = 7;
    localparam int RADIUS_W = 14;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int RAD2_W   = 2 * (RADIUS_W + 1);

    // op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_APPLY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // input word
    typedef struct packed {
        logic [1:0]                 op;
        logic [INDEX_W-1:0]         cell_index;
        logic signed [COORD_W-1:0]  cell_x;
        logic signed [COORD_W-1:0]  cell_z;
        logic signed [VALUE_W-1:0]  cell_init;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_z;
        logic signed [VALUE_W-1:0]  delta;
    } cmga_req_t;

    // result word
    typedef struct packed {
        logic signed [VALUE_W-1:0]  cell_value;
        logic [HIT_W-1:0]           hit_count;
    } cmga_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic              accept;
        logic              load_wr;
        logic              walk;
        logic [ADDR_W-1:0] walk_addr;
        logic              fin_zero;
        logic              fin_read;
        logic              fin_apply;
    } cmga_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_empty;
    } cmga_stat_t;

endpackage

// ===== src/cmga_ram.sv =====
module cmga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 81
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/cmga_ctrl.sv =====
module cmga_ctrl
    import cmga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  op,
    input  cmga_stat_t  stat,
    output cmga_cmd_t   cmd,
    output logic        busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_WALK  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept   = accept;
                cmd.load_wr  = accept && (op == OP_LOAD);
                cmd.fin_zero = accept && ((op == OP_LOAD) || (op == OP_NOP));
                cnt_next     = '0;
                if (accept && (op == OP_READ))
                begin
                    state_next = S_READ;
                end
                else if (accept && (op == OP_APPLY))
                begin
                    state_next = S_WALK;
                end
            end
            S_READ:
            begin
                cmd.fin_read = 1'b1;
                state_next   = S_IDLE;
            end
            S_WALK:
            begin
                // one cell read per cycle
                cmd.walk      = 1'b1;
                cmd.walk_addr = cnt_reg;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.fin_apply = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/cmga_dp.sv =====
module cmga_dp
    import cmga_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmga_req_t            req,
    input  logic                 cfg_we,
    input  logic [RADIUS_W-1:0]  cfg_wdata,
    input  cmga_cmd_t            cmd,
    output cmga_stat_t           stat,
    output logic                 done,
    output cmga_rsp_t            rsp
);

    // config and radius squared
    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic [RAD2_W-1:0]   rad2_reg, rad2_next;
    logic [RADIUS_W:0]   radius_eff;

    // per-item latches
    logic signed [COORD_W-1:0] cx_reg, cx_next;
    logic signed [COORD_W-1:0] cz_reg, cz_next;
    logic [VALUE_W-1:0]        delta_reg, delta_next;
    logic                      idx_ok_reg, idx_ok_next;
    logic                      idx_ok;
    logic [HIT_W-1:0]          hits_reg, hits_next;

    // memories
    logic [ADDR_W-1:0]        raddr;
    logic [2*COORD_W-1:0]     coord_rd;
    logic [VALUE_W-1:0]       value_rd;
    logic                     val_we;
    logic [ADDR_W-1:0]        val_waddr;
    logic [VALUE_W-1:0]       val_wdata;

    // walk pipeline
    logic                      v1_reg, v1_next;
    logic [ADDR_W-1:0]         a1_reg, a1_next;
    logic                      v2_reg, v2_next;
    logic [ADDR_W-1:0]         a2_reg, a2_next;
    logic signed [DIFF_W-1:0]  dx_reg, dx_next;
    logic signed [DIFF_W-1:0]  dz_reg, dz_next;
    logic [VALUE_W-1:0]        val2_reg, val2_next;
    logic                      v3_reg, v3_next;
    logic [ADDR_W-1:0]         a3_reg, a3_next;
    logic [SQ_W-1:0]           sqx_reg, sqx_next;
    logic [SQ_W-1:0]           sqz_reg, sqz_next;
    logic [VALUE_W-1:0]        val3_reg, val3_next;
    logic [COORD_W-1:0]        x_rd, z_rd;
    logic [DIST_W-1:0]         dist_sum;
    logic                      hit;

    // result register
    logic      done_reg, done_next;
    cmga_rsp_t rsp_reg, rsp_next;

    assign idx_ok = (32'(req.cell_index) < CELL_COUNT);

    // radius is twice the table word
    assign radius_eff  = {radius_reg, 1'b0};
    assign radius_next = cfg_we ? cfg_wdata : radius_reg;
    assign rad2_next   = radius_eff * radius_eff;

    // item latches
    always_comb
    begin
        cx_next     = cx_reg;
        cz_next     = cz_reg;
        delta_next  = delta_reg;
        idx_ok_next = idx_ok_reg;
        if (cmd.accept)
        begin
            cx_next     = req.center_x;
            cz_next     = req.center_z;
            delta_next  = req.delta;
            idx_ok_next = idx_ok;
        end
    end

    // memory ports
    assign raddr     = cmd.walk ? cmd.walk_addr : ADDR_W'(req.cell_index);
    assign val_we    = (cmd.load_wr && idx_ok) || hit;
    assign val_waddr = hit ? a3_reg : ADDR_W'(req.cell_index);
    assign val_wdata = hit ? (val3_reg + delta_reg) : req.cell_init;

    cmga_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (CELL_COUNT)
    ) u_coord_ram (
        .clk   (clk),
        .we    (cmd.load_wr && idx_ok),
        .waddr (ADDR_W'(req.cell_index)),
        .wdata ({req.cell_x, req.cell_z}),
        .raddr (raddr),
        .rdata (coord_rd)
    );

    cmga_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CELL_COUNT)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (raddr),
        .rdata (value_rd)
    );

    assign x_rd = coord_rd[2*COORD_W-1:COORD_W];
    assign z_rd = coord_rd[COORD_W-1:0];

    // stage 1: differences
    assign v1_next   = cmd.walk;
    assign a1_next   = cmd.walk_addr;
    assign v2_next   = v1_reg;
    assign a2_next   = a1_reg;
    assign dx_next   = {cx_reg[COORD_W-1], cx_reg} - {x_rd[COORD_W-1], x_rd};
    assign dz_next   = {cz_reg[COORD_W-1], cz_reg} - {z_rd[COORD_W-1], z_rd};
    assign val2_next = value_rd;

    // stage 2: squares
    assign v3_next   = v2_reg;
    assign a3_next   = a2_reg;
    assign sqx_next  = dx_reg * dx_reg;
    assign sqz_next  = dz_reg * dz_reg;
    assign val3_next = val2_reg;

    // stage 3: strict compare, write back
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqz_reg);
    assign hit      = v3_reg && (dist_sum < DIST_W'(rad2_reg));

    assign hits_next = cmd.accept ? '0 : (hit ? hits_reg + 1'b1 : hits_reg);

    assign stat.pipe_empty = !(v1_reg || v2_reg || v3_reg);

    // result word
    always_comb
    begin
        rsp_next  = '0;
        done_next = cmd.fin_zero || cmd.fin_read || cmd.fin_apply;
        if (cmd.fin_read && idx_ok_reg)
        begin
            rsp_next.cell_value = value_rd;
        end
        if (cmd.fin_apply)
        begin
            rsp_next.hit_count = hits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            hits_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            radius_reg <= radius_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            v3_reg     <= v3_next;
            hits_reg   <= hits_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad2_reg   <= rad2_next;
        cx_reg     <= cx_next;
        cz_reg     <= cz_next;
        delta_reg  <= delta_next;
        idx_ok_reg <= idx_ok_next;
        a1_reg     <= a1_next;
        a2_reg     <= a2_next;
        dx_reg     <= dx_next;
        dz_reg     <= dz_next;
        val2_reg   <= val2_next;
        a3_reg     <= a3_next;
        sqx_reg    <= sqx_next;
        sqz_reg    <= sqz_next;
        val3_reg   <= val3_next;
        rsp_reg    <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== src/circle_masked_grid_add.sv =====
// A word is taken when start is high and busy is low; its result word appears on rsp for
// exactly one cycle with done high and cannot be held off. Load and the unused op give
// their result in the next cycle and never raise busy, so one may follow every cycle.
// Read raises busy for one cycle and gives its result from the registered memory read. Apply
// walks every grid cell through the single read port of the cell memories, one cell a
// cycle, behind a three-stage difference, square and compare pipeline: busy stays high
// through the walk and the pipeline drain, and the result appears as busy falls.
// The radius register may be written at any idle cycle, right up to the accepting edge.
module circle_masked_grid_add
    import cmga_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cmga_req_t            req,
    output logic                 busy,
    output logic                 done,
    output cmga_rsp_t            rsp,
    input  logic                 cfg_we,
    input  logic [RADIUS_W-1:0]  cfg_wdata
);

    cmga_cmd_t  cmd;
    cmga_stat_t stat;

    cmga_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (req.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cmga_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // a result is only shown once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // load and unused op answer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.op == OP_LOAD || req.op == OP_NOP)) |=> done)
        else $error("load word gave no result");

    // read answers from its registered memory read through the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.op == OP_READ) |-> ##2 done)
        else $error("read word gave no result");

    // cell walk never overlaps a load write
    assert property (@(posedge clk) disable iff (!rst_n) cmd.walk |-> !cmd.load_wr && busy)
        else $error("walk overlaps load");
`endif

endmodule
